// ===== rtl/rhht_pkg.sv =====
// rhht_pkg: shared command codes, result codes and control structs
// for the robin hood hash table unit; no dependencies
package rhht_pkg;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_LOOKUP = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_UPDATED   = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_REMOVED   = 3'd4;
    localparam t_status ST_FULL      = 3'd5;

    typedef struct packed {
        logic    load_item;
        logic    calc_home;
        logic    find_read;
        logic    find_next;
        logic    insert_start;
        logic    place_read;
        logic    place_write;
        logic    place_step;
        logic    upd_write;
        logic    shift_start;
        logic    shift_read;
        logic    shift_move;
        logic    shift_clear;
        logic    clr_write;
        logic    count_inc;
        logic    count_dec;
        logic    res_we;
        t_status res_code;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic d_over;
        logic rd_used;
        logic key_eq;
        logic rd_evict;
        logic rd_dist_zero;
        logic nx_is_pos;
        logic full;
        logic first;
        logic clr_last;
    } t_dp_stat;

endpackage

// ===== rtl/rhht_ctrl.sv =====
// rhht_ctrl: sequencer for probe, placement, backward shift and clearing
// depends on rhht_pkg
module rhht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  rhht_pkg::t_dp_stat i_st,
    output rhht_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import rhht_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HOME  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCK   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCK   = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SCK   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    c;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = c;

    always_comb begin
        c           = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                c.clr_write = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load_item = 1'b1;
                    n_state     = S_HOME;
                end
            end
            S_HOME: begin
                c.calc_home = 1'b1;
                n_state     = S_FRD;
            end
            S_FRD: begin
                if (i_st.op != OP_INSERT && i_st.op != OP_LOOKUP && i_st.op != OP_REMOVE) begin
                    c.res_we   = 1'b1;
                    c.res_code = ST_NOT_FOUND;
                    n_state    = S_DONE;
                end else if (i_st.d_over) begin
                    if (i_st.op != OP_INSERT) begin
                        c.res_we   = 1'b1;
                        c.res_code = ST_NOT_FOUND;
                        n_state    = S_DONE;
                    end else if (i_st.full) begin
                        c.res_we   = 1'b1;
                        c.res_code = ST_FULL;
                        n_state    = S_DONE;
                    end else begin
                        c.insert_start = 1'b1;
                        n_state        = S_PRD;
                    end
                end else begin
                    c.find_read = 1'b1;
                    n_state     = S_FCK;
                end
            end
            S_FCK: begin
                if (!i_st.rd_used) begin
                    if (i_st.op != OP_INSERT) begin
                        c.res_we   = 1'b1;
                        c.res_code = ST_NOT_FOUND;
                        n_state    = S_DONE;
                    end else if (i_st.full) begin
                        c.res_we   = 1'b1;
                        c.res_code = ST_FULL;
                        n_state    = S_DONE;
                    end else begin
                        c.insert_start = 1'b1;
                        n_state        = S_PRD;
                    end
                end else if (i_st.key_eq) begin
                    c.res_we = 1'b1;
                    case (i_st.op)
                        OP_INSERT: begin
                            c.upd_write = 1'b1;
                            c.res_code  = ST_UPDATED;
                            n_state     = S_DONE;
                        end
                        OP_REMOVE: begin
                            c.res_code    = ST_REMOVED;
                            c.count_dec   = 1'b1;
                            c.shift_start = 1'b1;
                            n_state       = S_SRD;
                        end
                        default: begin
                            c.res_code = ST_FOUND;
                            n_state    = S_DONE;
                        end
                    endcase
                end else begin
                    c.find_next = 1'b1;
                    n_state     = S_FRD;
                end
            end
            S_PRD: begin
                c.place_read = 1'b1;
                n_state      = S_PCK;
            end
            S_PCK: begin
                c.place_step = 1'b1;
                n_state      = S_PRD;
                if (!i_st.rd_used || i_st.rd_evict) begin
                    c.place_write = 1'b1;
                    if (i_st.first) begin
                        c.res_we    = 1'b1;
                        c.res_code  = ST_INSERTED;
                        c.count_inc = 1'b1;
                    end
                    if (!i_st.rd_used) n_state = S_DONE;
                end
            end
            S_SRD: begin
                if (i_st.nx_is_pos) begin
                    c.shift_clear = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    c.shift_read = 1'b1;
                    n_state      = S_SCK;
                end
            end
            S_SCK: begin
                if (!i_st.rd_used || i_st.rd_dist_zero) begin
                    c.shift_clear = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    c.shift_move = 1'b1;
                    n_state      = S_SRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    c.out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/rhht_dp.sv =====
// rhht_dp: slot memory, home slot multiplier, probe counters and result registers
// depends on rhht_pkg
module rhht_dp #(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_key_hash,
    input  logic [31:0]        i_value,
    input  rhht_pkg::t_dp_cmd  i_cmd,
    output rhht_pkg::t_dp_stat o_st,
    output logic [2:0]         o_status,
    output logic [31:0]        o_found_value,
    output logic [7:0]         o_probe_distance
);
    import rhht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CAP_W = $clog2(SLOTS + 1);
    localparam int CFG_W = (CAP_W > 9) ? CAP_W : 9;
    localparam int SAT_W = (CAP_W > 8) ? CAP_W : 8;
    localparam int KX_W  = (KEY_BITS > 32) ? KEY_BITS : 32;
    localparam int VX_W  = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // slot memory, one write and one registered read per cycle
    logic                  mem_used [SLOTS];
    logic [IDX_W-1:0]      mem_dist [SLOTS];
    logic [KEY_BITS-1:0]   mem_key  [SLOTS];
    logic [VALUE_BITS-1:0] mem_val  [SLOTS];

    logic                  r_rd_used;
    logic [IDX_W-1:0]      r_rd_dist;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    logic [CAP_W-1:0]      r_cap, r_largest, r_count, r_d, r_cd;
    logic [IDX_W-1:0]      r_home, r_pos, r_i, r_clr;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key, r_ck;
    logic [VALUE_BITS-1:0] r_val, r_cv;
    logic [31:0]           r_hash;
    logic                  r_first;
    t_status               r_res_code;
    logic [31:0]           r_res_val;
    logic [7:0]            r_res_dist;
    t_status               r_o_status;
    logic [31:0]           r_o_val;
    logic [7:0]            r_o_dist;

    logic [32+CAP_W-1:0]   prod;
    logic [IDX_W-1:0]      home_w, pos_nx, i_nx;
    logic [CFG_W-1:0]      cfg_x;
    logic [CAP_W-1:0]      cap_new;
    logic [KX_W-1:0]       key_x;
    logic [VX_W-1:0]       val_x, rdval_x;
    logic                  rd_en, wr_en, wr_used;
    logic [IDX_W-1:0]      rd_addr, wr_addr, wr_dist;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [CAP_W-1:0]      rd_dist_x;

    function automatic logic [7:0] sat8(input logic [CAP_W-1:0] v);
        logic [SAT_W-1:0] x;
        x = SAT_W'(v);
        return (x > SAT_W'(255)) ? 8'hFF : x[7:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v,
                                                  input logic [CAP_W-1:0] cap);
        return (CAP_W'(v) + CAP_W'(1) >= cap) ? '0 : v + IDX_W'(1);
    endfunction

    assign prod      = {CAP_W'(0), r_hash} * {32'd0, r_cap};
    assign home_w    = prod[32+IDX_W-1:32];
    assign pos_nx    = wrap_inc(r_pos, r_cap);
    assign i_nx      = wrap_inc(r_i, r_cap);
    assign cfg_x     = CFG_W'(i_cfg_wdata);
    assign cap_new   = (cfg_x == '0) ? CAP_W'(1) :
                       (cfg_x > CFG_W'(SLOTS)) ? CAP_W'(SLOTS) : cfg_x[CAP_W-1:0];
    assign key_x     = KX_W'(i_key);
    assign val_x     = VX_W'(i_value);
    assign rdval_x   = VX_W'(r_rd_val);
    assign rd_dist_x = CAP_W'(r_rd_dist);

    always_comb begin
        rd_en   = i_cmd.find_read | i_cmd.place_read | i_cmd.shift_read;
        rd_addr = i_cmd.find_read ? r_pos : i_cmd.place_read ? r_i : i_nx;
        wr_en   = 1'b1;
        wr_used = 1'b0;
        wr_addr = r_i;
        wr_dist = r_rd_dist;
        wr_key  = r_rd_key;
        wr_val  = r_rd_val;
        if (i_cmd.clr_write) begin
            wr_addr = r_clr;
        end else if (i_cmd.upd_write) begin
            wr_addr = r_pos;
            wr_used = 1'b1;
            wr_val  = r_val;
        end else if (i_cmd.place_write) begin
            wr_used = 1'b1;
            wr_dist = r_cd[IDX_W-1:0];
            wr_key  = r_ck;
            wr_val  = r_cv;
        end else if (i_cmd.shift_move) begin
            wr_used = 1'b1;
            wr_dist = r_rd_dist - IDX_W'(1);
        end else if (!i_cmd.shift_clear) begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_used[wr_addr] <= wr_used;
            mem_dist[wr_addr] <= wr_dist;
            mem_key[wr_addr]  <= wr_key;
            mem_val[wr_addr]  <= wr_val;
        end
        if (rd_en) begin
            r_rd_used <= mem_used[rd_addr];
            r_rd_dist <= mem_dist[rd_addr];
            r_rd_key  <= mem_key[rd_addr];
            r_rd_val  <= mem_val[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_W'(SLOTS);
            r_largest <= '0;
            r_count   <= '0;
            r_clr     <= '0;
        end else if (i_cfg_we) begin
            r_cap     <= cap_new;
            r_largest <= '0;
            r_count   <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cmd.clr_write) r_clr <= r_clr + IDX_W'(1);
            if (i_cmd.count_inc) r_count <= r_count + CAP_W'(1);
            if (i_cmd.count_dec && r_count != '0) r_count <= r_count - CAP_W'(1);
            if (i_cmd.place_write && r_cd > r_largest) r_largest <= r_cd;
        end
    end

    // item and probe registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_command;
            r_key  <= key_x[KEY_BITS-1:0];
            r_val  <= val_x[VALUE_BITS-1:0];
            r_hash <= i_key_hash;
        end
        if (i_cmd.calc_home) begin
            r_home <= home_w;
            r_pos  <= home_w;
            r_d    <= '0;
        end
        if (i_cmd.find_next) begin
            r_pos <= pos_nx;
            r_d   <= r_d + CAP_W'(1);
        end
        if (i_cmd.insert_start) begin
            r_ck    <= r_key;
            r_cv    <= r_val;
            r_cd    <= '0;
            r_i     <= r_home;
            r_first <= 1'b1;
        end
        if (i_cmd.place_step) begin
            r_i <= i_nx;
            if (i_cmd.place_write) begin
                r_first <= 1'b0;
                r_ck    <= r_rd_key;
                r_cv    <= r_rd_val;
                r_cd    <= rd_dist_x + CAP_W'(1);
            end else begin
                r_cd <= r_cd + CAP_W'(1);
            end
        end
        if (i_cmd.shift_start) r_i <= r_pos;
        if (i_cmd.shift_move) r_i <= i_nx;
        if (i_cmd.res_we) begin
            r_res_code <= i_cmd.res_code;
            r_res_val  <= (i_cmd.res_code == ST_FOUND || i_cmd.res_code == ST_REMOVED) ?
                          rdval_x[31:0] : 32'd0;
            if (i_cmd.res_code == ST_INSERTED) r_res_dist <= sat8(r_cd);
            else if (i_cmd.res_code == ST_NOT_FOUND || i_cmd.res_code == ST_FULL)
                r_res_dist <= 8'd0;
            else r_res_dist <= sat8(r_d);
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_code;
            r_o_val    <= r_res_val;
            r_o_dist   <= r_res_dist;
        end
    end

    always_comb begin
        o_st.op           = r_op;
        o_st.d_over       = (r_d > r_largest) || (r_d >= r_cap);
        o_st.rd_used      = r_rd_used;
        o_st.key_eq       = (r_rd_key == r_key);
        o_st.rd_evict     = (rd_dist_x < r_cd);
        o_st.rd_dist_zero = (r_rd_dist == '0);
        o_st.nx_is_pos    = (i_nx == r_pos);
        o_st.full         = (r_count >= r_cap);
        o_st.first        = r_first;
        o_st.clr_last     = (CAP_W'(r_clr) == CAP_W'(SLOTS - 1));
    end

    assign o_status         = r_o_status;
    assign o_found_value    = r_o_val;
    assign o_probe_distance = r_o_dist;

endmodule

// ===== rtl/robin_hood_hash_table_unit.sv =====
// robin hood hash table: insert, lookup and remove with backward shift deletion
// throughput: one transaction at a time, a new request waits until the previous result is loaded
// reset (synchronous, active low) and every capacity write start a clearing pass over
// every slot of the slot memory, during which no transaction is accepted
// depends on rhht_pkg, rhht_ctrl, rhht_dp
module robin_hood_hash_table_unit #(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capacity register write
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [7:0]  o_probe_distance
);
    import rhht_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  cmd;
    t_dp_stat st;

    rhht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rhht_dp #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_command        (i_command),
        .i_key            (i_key),
        .i_key_hash       (i_key_hash),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_status         (o_status),
        .o_found_value    (o_found_value),
        .o_probe_distance (o_probe_distance)
    );

    // a capacity write always holds off requests while the table clears
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("request taken during clearing pass");

    // at most one source drives the slot memory write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.upd_write, cmd.place_write, cmd.shift_move, cmd.shift_clear,
                  cmd.clr_write}))
        else $error("slot memory write conflict");

    // a result never appears in the cycle right after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !cmd.out_load)
        else $error("result loaded before any probe");

endmodule

// ===== sim/testbench.sv =====
// testbench for robin_hood_hash_table_unit: directed table then random traffic,
// every transaction checked against an in-bench model of the robin hood table
// depends on rhht_pkg and robin_hood_hash_table_unit
`timescale 1ns / 100ps

module testbench;
    import rhht_pkg::*;

    localparam int NSLOT = 256;
    localparam t_op OP_BAD = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command = '0;
    logic [31:0] i_key = '0;
    logic [31:0] i_key_hash = '0;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_found_value;
    logic [7:0]  o_probe_distance;

    always #2 i_clk = ~i_clk;

    robin_hood_hash_table_unit u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid, .o_in_stall, .i_command, .i_key, .i_key_hash, .i_value,
        .o_out_valid, .i_out_stall, .o_status, .o_found_value, .o_probe_distance
    );

    typedef struct packed {
        t_status     status;
        logic [31:0] fval;
        logic [7:0]  pdist;
    } t_answer;

    // table model state
    bit          tbl_used [NSLOT];
    logic [31:0] tbl_key  [NSLOT];
    logic [31:0] tbl_val  [NSLOT];
    int          tbl_dist [NSLOT];
    int          max_probe;
    int          n_entries;
    int          cap;

    t_answer     pending_answers[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_full = 0;
    bit          stall_hold = 1'b0;   // forces a long receiver hold-off
    bit          idle_enable = 1'b1;  // random idling on or off

    // most keys used by the random part are drawn from a small pool so hits happen
    logic [31:0] pool_key  [64];
    logic [31:0] pool_hash [64];

    function automatic void table_clear(int new_cap);
        for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
        max_probe = 0;
        n_entries = 0;
        cap = (new_cap == 0) ? 1 : (new_cap > NSLOT ? NSLOT : new_cap);
    endfunction

    // search bounded by the largest probe distance, stops at a hole
    function automatic bit table_find(logic [31:0] k, int home, output int pos,
                                      output int d);
        int s;
        pos = 0;
        d = 0;
        for (s = 0; s <= max_probe && s < cap; s++) begin
            if (!tbl_used[(home + s) % cap]) return 1'b0;
            if (tbl_key[(home + s) % cap] == k) begin
                pos = (home + s) % cap;
                d = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] clip8(int d);
        return (d > 255) ? 8'd255 : d[7:0];
    endfunction

    function automatic t_answer table_apply(t_op op, logic [31:0] k, logic [31:0] h,
                                            logic [31:0] v);
        t_answer a;
        int home, pos, d, i, cd, own_d, td, nx;
        bit placed, was;
        logic [31:0] ck, cv, tk, tv;
        a = '{ST_NOT_FOUND, 32'd0, 8'd0};
        home = int'((64'(h) * 64'(cap)) >> 32);
        case (op)
            OP_INSERT: begin
                if (table_find(k, home, pos, d)) begin
                    tbl_val[pos] = v;
                    a = '{ST_UPDATED, 32'd0, clip8(d)};
                end else if (n_entries >= cap) begin
                    a.status = ST_FULL;
                end else begin
                    // carry the entry forward, swapping with richer residents
                    ck = k; cv = v; cd = 0; i = home; placed = 0; own_d = 0;
                    for (int n = 0; n <= cap; n++) begin
                        if (!tbl_used[i] || tbl_dist[i] < cd) begin
                            was = tbl_used[i];
                            tk = tbl_key[i]; tv = tbl_val[i]; td = tbl_dist[i];
                            tbl_used[i] = 1'b1;
                            tbl_key[i] = ck; tbl_val[i] = cv; tbl_dist[i] = cd;
                            if (cd > max_probe) max_probe = cd;
                            if (!placed) begin
                                placed = 1;
                                own_d = cd;
                            end
                            if (!was) break;
                            ck = tk; cv = tv; cd = td;
                        end
                        i = (i + 1) % cap;
                        cd++;
                    end
                    n_entries++;
                    a = '{ST_INSERTED, 32'd0, clip8(own_d)};
                end
            end
            OP_LOOKUP: begin
                if (table_find(k, home, pos, d))
                    a = '{ST_FOUND, tbl_val[pos], clip8(d)};
            end
            OP_REMOVE: begin
                if (table_find(k, home, pos, d)) begin
                    a = '{ST_REMOVED, tbl_val[pos], clip8(d)};
                    // backward shift until a hole or an entry at home
                    i = pos;
                    for (int n = 0; n < cap; n++) begin
                        nx = (i + 1) % cap;
                        if (nx == pos || !tbl_used[nx] || tbl_dist[nx] == 0) break;
                        tbl_key[i] = tbl_key[nx];
                        tbl_val[i] = tbl_val[nx];
                        tbl_dist[i] = tbl_dist[nx] - 1;
                        i = nx;
                    end
                    tbl_used[i] = 1'b0;
                    if (n_entries > 0) n_entries--;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // one transaction on the request channel, prediction made at acceptance
    // valid stays high after acceptance so back-to-back requests need no gap
    task automatic send_request(t_op op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        while (idle_enable && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= op;
        i_key <= k;
        i_key_hash <= h;
        i_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_answers.push_back(table_apply(op, k, h, v));
        n_sent++;
    endtask

    task automatic drain_answers();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // capacity write only while idle; the unit then runs its clearing pass
    task automatic set_capacity(logic [8:0] c);
        drain_answers();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_clear(int'(c));
    endtask

    // receiver: random stalls, plus a forced hold-off when asked
    always @(posedge i_clk) begin
        if (stall_hold) i_out_stall <= 1'b1;
        else if (idle_enable) i_out_stall <= ($urandom_range(99) < 17);
        else i_out_stall <= 1'b0;
    end

    // result checker, field by field against the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result with no transaction outstanding: status %0d", o_status);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                if (o_status == ST_FULL) n_full++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_found_value !== want.fval) begin
                    $error("found_value: expected %h, got %h", want.fval, o_found_value);
                    errors++;
                end
                if (o_probe_distance !== want.pdist) begin
                    $error("probe_distance: expected %0d, got %0d", want.pdist,
                           o_probe_distance);
                    errors++;
                end
            end
        end
    end

    // directed rows; a row with check set also carries a typed-in answer
    typedef struct {
        t_op         op;
        logic [31:0] k;
        logic [31:0] h;
        logic [31:0] v;
        bit          check;
        t_answer     ans;
    } t_row;

    t_row dir_rows[] = '{
        '{OP_LOOKUP, 32'h0,        32'h0,        32'h0,        1, '{ST_NOT_FOUND, 0, 0}},
        '{OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1, '{ST_NOT_FOUND, 0, 0}},
        '{OP_INSERT, 32'h0,        32'h0,        32'hFFFFFFFF, 1, '{ST_INSERTED, 0, 0}},
        '{OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1, '{ST_INSERTED, 0, 0}},
        '{OP_INSERT, 32'h5,        32'h0,        32'hA5A5A5A5, 1, '{ST_INSERTED, 0, 1}},
        '{OP_INSERT, 32'h6,        32'h00000001, 32'h5A5A5A5A, 0, '{ST_INSERTED, 0, 0}},
        '{OP_INSERT, 32'h5,        32'h0,        32'h12345678, 1, '{ST_UPDATED, 0, 1}},
        '{OP_LOOKUP, 32'h5,        32'h0,        32'h0,        1, '{ST_FOUND, 32'h12345678, 1}},
        '{OP_LOOKUP, 32'h0,        32'h0,        32'h0,        1, '{ST_FOUND, 32'hFFFFFFFF, 0}},
        '{OP_BAD,    32'h5,        32'h0,        32'hFFFFFFFF, 1, '{ST_NOT_FOUND, 0, 0}},
        '{OP_REMOVE, 32'h0,        32'h0,        32'h0,        1, '{ST_REMOVED, 32'hFFFFFFFF, 0}},
        '{OP_LOOKUP, 32'h5,        32'h0,        32'h0,        0, '{ST_FOUND, 0, 0}},
        '{OP_LOOKUP, 32'h6,        32'h00000001, 32'h0,        0, '{ST_FOUND, 0, 0}},
        '{OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        0, '{ST_REMOVED, 0, 0}},
        '{OP_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1, '{ST_NOT_FOUND, 0, 0}}
    };

    // random mix on the key pool: inserts weighted up so the table fills
    task automatic random_burst(int count, int pool_n);
        int idx, r;
        t_op op;
        for (int n = 0; n < count; n++) begin
            idx = $urandom_range(pool_n - 1);
            r = $urandom_range(99);
            op = (r < 50) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 97) ? OP_REMOVE : OP_BAD;
            if ($urandom_range(19) == 0)
                send_request(op, $urandom, $urandom, $urandom);
            else
                send_request(op, pool_key[idx], pool_hash[idx], $urandom);
        end
    endtask

    initial begin
        t_answer mirror;
        for (int i = 0; i < 64; i++) begin
            pool_key[i] = $urandom;
            // some hashes collide on purpose to build long probe chains
            pool_hash[i] = (i % 4 == 0 && i != 0) ? pool_hash[0] ^ $urandom_range(255)
                                                   : $urandom;
        end
        pool_key[1] = 32'hFFFFFFFF;
        pool_hash[1] = 32'hFFFFFFFF;
        table_clear(NSLOT);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset capacity
        foreach (dir_rows[r]) begin
            send_request(dir_rows[r].op, dir_rows[r].k, dir_rows[r].h, dir_rows[r].v);
            mirror = pending_answers[$];
            if (dir_rows[r].check && mirror !== dir_rows[r].ans) begin
                $error("directed row %0d: table model disagrees with typed answer", r);
                errors++;
            end
        end

        // table full: capacity 1 by the zero-as-one case, and capacity 2
        set_capacity(9'd0);
        send_request(OP_INSERT, 32'h11, 32'h0, 32'h1);
        send_request(OP_INSERT, 32'h22, 32'hFFFFFFFF, 32'h2);
        send_request(OP_LOOKUP, 32'h11, 32'h0, 32'h0);
        set_capacity(9'd2);
        for (int i = 0; i < 4; i++) send_request(OP_INSERT, i, 32'h0, i);
        send_request(OP_REMOVE, 32'd0, 32'h0, 32'h0);
        send_request(OP_LOOKUP, 32'd1, 32'h0, 32'h0);
        // above the slot count clamps to the full size
        set_capacity(9'h1FF);
        send_request(OP_INSERT, 32'h77, 32'hFFFFFFFF, 32'h7);

        // random phases over several capacities, small ones to reach full
        set_capacity(9'd256);
        random_burst(300, 64);
        set_capacity(9'd5);
        random_burst(150, 12);
        set_capacity(9'd1);
        random_burst(40, 3);
        set_capacity(9'd37);
        random_burst(250, 64);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                stall_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                stall_hold = 1'b0;
            end
            random_burst(20, 64);
        join
        // sender waits until all results are back
        drain_answers();
        set_capacity(9'd256);
        idle_enable = 1'b0;
        random_burst(250, 64);
        idle_enable = 1'b1;
        set_capacity(9'd64);
        random_burst(350, 64);

        drain_answers();
        $display("%0d transactions sent, %0d results checked, %0d table-full answers",
                 n_sent, n_checked, n_full);
        $display("capacities 1, 2, 5, 37, 64 and 256 with clamped writes of 0 and 511");
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rhht_pkg.sv
rtl/rhht_ctrl.sv
rtl/rhht_dp.sv
rtl/robin_hood_hash_table_unit.sv
sim/testbench.sv
